@@ src/mdst_pkg.sv @@
// Shared constants and types for the minimum arborescence solver.
package mdst_pkg;

  localparam int MAX_V   = 256;
  localparam int MAX_E   = 16384;
  localparam int WB      = 20;
  localparam int VW      = 9;
  localparam int EAW     = $clog2(MAX_E);
  localparam int ECW     = EAW + 1;
  localparam int ACCW    = 40;

  localparam logic [WB:0] NO_EDGE = {1'b1, {WB{1'b0}}};

  localparam logic [1:0] STAT_FOUND       = 2'd0;
  localparam logic [1:0] STAT_UNREACHABLE = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW    = 2'd2;

  localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;
  localparam logic [1:0] REG_ROOT_VERTEX  = 2'd1;

  typedef struct packed {
    logic [VW-1:0] tail;
    logic [VW-1:0] head;
    logic [WB-1:0] weight;
  } edge_t;

endpackage

@@ src/min_directed_spanning_tree_core.sv @@
// Minimum directed spanning tree (Chu-Liu/Edmonds) solver top level.
//
// Edges enter on the in_ channel, one transfer per edge, and are written to
// the edge store while it has room. The transfer with in_last_edge set
// starts the solve; it yields one transfer on the out_ channel with the
// total weight and a status (found, unreachable, store overflowed).
// Configuration (vertex count, root) must be written on the cfg_ channel
// only while the block is idle (unenforced); cfg_ready is always high.
// The solve runs on one shared sequencer over block memories with
// registered reads. Each round runs table clear, selection, check, walk,
// relabel, contraction and root relabel; one filter pass comes before the
// first round. A round count up to the vertex count bounds the whole
// solve. Overflow and out-of-range root results appear in the cycle after
// the last edge.
// in_ready is low during the solve and while a result is held unaccepted
// on out_; a stalled receiver simply holds the block.
// Reset (synchronous, rst_n low) empties the edge store, clears the
// overflow flag and sets vertex count and root to 1. Store contents and
// vertex tables need no clearing; each round clears what it uses.
module min_directed_spanning_tree_core
  import mdst_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [VW-1:0] in_edge_source,
  input  logic [VW-1:0] in_edge_target,
  input  logic [WB-1:0] in_edge_weight,
  input  logic          in_last_edge,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   out_total_weight,
  output logic [1:0]    out_status,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [VW-1:0] cfg_data
);

  typedef enum logic [19:0] {
    ST_IDLE  = 20'b00000000000000000001,
    ST_FRD   = 20'b00000000000000000010,
    ST_FEX   = 20'b00000000000000000100,
    ST_CLR   = 20'b00000000000000001000,
    ST_BRD   = 20'b00000000000000010000,
    ST_BW    = 20'b00000000000000100000,
    ST_BEX   = 20'b00000000000001000000,
    ST_CRD   = 20'b00000000000010000000,
    ST_CEX   = 20'b00000000000100000000,
    ST_WI    = 20'b00000000001000000000,
    ST_WADD  = 20'b00000000010000000000,
    ST_WEX   = 20'b00000000100000000000,
    ST_CYC   = 20'b00000001000000000000,
    ST_RRD   = 20'b00000010000000000000,
    ST_REX   = 20'b00000100000000000000,
    ST_KRD   = 20'b00001000000000000000,
    ST_KW    = 20'b00010000000000000000,
    ST_KEX   = 20'b00100000000000000000,
    ST_ROOT  = 20'b01000000000000000000,
    ST_ROOT2 = 20'b10000000000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [VW-1:0]   vcnt_r, vcnt_nxt;
  logic [VW-1:0]   rcfg_r, rcfg_nxt;
  logic [ECW-1:0]  ecnt_r, ecnt_nxt;
  logic            ovf_r, ovf_nxt;
  logic [ECW-1:0]  m_r, m_nxt;
  logic [ECW-1:0]  k_r, k_nxt;
  logic [ECW-1:0]  kept_r, kept_nxt;
  logic [VW-1:0]   n_r, n_nxt;
  logic [VW-1:0]   croot_r, croot_nxt;
  logic [VW-1:0]   lbl_r, lbl_nxt;
  logic [VW-1:0]   i_r, i_nxt;
  logic [VW-1:0]   u_r, u_nxt;
  logic [VW-1:0]   v_r, v_nxt;
  logic [ACCW-1:0] total_r, total_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     out_total_r, out_total_nxt;
  logic [1:0]      out_status_r, out_status_nxt;

  // edge store
  logic           e_we;
  logic [EAW-1:0] e_waddr;
  edge_t          e_wdata;
  edge_t          e_rd;

  mdst_edge_mem u_edge_mem (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (k_r[EAW-1:0]),
    .rdata (e_rd)
  );

  // vertex tables
  logic [WB:0]   bw_mem   [0:MAX_V];
  logic [VW-1:0] par_mem  [0:MAX_V];
  logic [VW-1:0] mark_mem [0:MAX_V];
  logic [VW-1:0] lab_mem  [0:MAX_V];

  logic          bw_we, par_we, mark_we, lab_we;
  logic [VW-1:0] bw_wa, par_wa, mark_wa, lab_wa;
  logic [WB:0]   bw_wd;
  logic [VW-1:0] par_wd, mark_wd, lab_wd;
  logic [VW-1:0] va, vb;
  logic [WB:0]   bw_rd;
  logic [VW-1:0] par_rd, mark_rd, laba_rd, labb_rd;

  always_ff @(posedge clk) begin
    if (bw_we) begin
      bw_mem[bw_wa] <= bw_wd;
    end
    if (par_we) begin
      par_mem[par_wa] <= par_wd;
    end
    if (mark_we) begin
      mark_mem[mark_wa] <= mark_wd;
    end
    if (lab_we) begin
      lab_mem[lab_wa] <= lab_wd;
    end
    bw_rd   <= bw_mem[vb];
    par_rd  <= par_mem[va];
    mark_rd <= mark_mem[va];
    laba_rd <= lab_mem[va];
    labb_rd <= lab_mem[vb];
  end

  logic           in_xfer;
  logic           full;
  logic [VW-1:0]  n_cap;
  logic           t_ok, h_ok;
  logic [ECW-1:0] k_inc;

  assign in_xfer = in_valid && in_ready;
  assign full    = (ecnt_r == ECW'(MAX_E));
  assign n_cap   = (vcnt_r > VW'(MAX_V)) ? VW'(MAX_V) : vcnt_r;
  assign t_ok    = (e_rd.tail != '0) && (e_rd.tail <= n_r);
  assign h_ok    = (e_rd.head != '0) && (e_rd.head <= n_r);
  assign k_inc   = k_r + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    vcnt_nxt       = vcnt_r;
    rcfg_nxt       = rcfg_r;
    ecnt_nxt       = ecnt_r;
    ovf_nxt        = ovf_r;
    m_nxt          = m_r;
    k_nxt          = k_r;
    kept_nxt       = kept_r;
    n_nxt          = n_r;
    croot_nxt      = croot_r;
    lbl_nxt        = lbl_r;
    i_nxt          = i_r;
    u_nxt          = u_r;
    v_nxt          = v_r;
    total_nxt      = total_r;
    out_valid_nxt  = out_valid_r;
    out_total_nxt  = out_total_r;
    out_status_nxt = out_status_r;
    e_we           = 1'b0;
    e_waddr        = kept_r[EAW-1:0];
    e_wdata        = e_rd;
    bw_we          = 1'b0;
    par_we         = 1'b0;
    mark_we        = 1'b0;
    lab_we         = 1'b0;
    bw_wa          = i_r;
    par_wa         = i_r;
    mark_wa        = i_r;
    lab_wa         = i_r;
    bw_wd          = NO_EDGE;
    par_wd         = '0;
    mark_wd        = '0;
    lab_wd         = '0;
    va             = i_r;
    vb             = i_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid) begin
      if (cfg_index == REG_VERTEX_COUNT) begin
        vcnt_nxt = cfg_data;
      end else if (cfg_index == REG_ROOT_VERTEX) begin
        rcfg_nxt = cfg_data;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (!full) begin
            e_we         = 1'b1;
            e_waddr      = ecnt_r[EAW-1:0];
            e_wdata.tail = in_edge_source;
            e_wdata.head = in_edge_target;
            e_wdata.weight = in_edge_weight;
            ecnt_nxt     = ecnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_edge) begin
            ecnt_nxt  = '0;
            ovf_nxt   = 1'b0;
            total_nxt = '0;
            n_nxt     = n_cap;
            croot_nxt = rcfg_r;
            if (ovf_r || full) begin
              out_valid_nxt  = 1'b1;
              out_total_nxt  = '0;
              out_status_nxt = STAT_OVERFLOW;
            end else if (rcfg_r == '0 || rcfg_r > n_cap) begin
              out_valid_nxt  = 1'b1;
              out_total_nxt  = '0;
              out_status_nxt = STAT_UNREACHABLE;
            end else begin
              m_nxt     = ecnt_r + 1'b1;
              k_nxt     = '0;
              kept_nxt  = '0;
              state_nxt = ST_FRD;
            end
          end
        end
      end
      ST_FRD: state_nxt = ST_FEX;
      ST_FEX: begin
        if (t_ok && h_ok) begin
          e_we     = 1'b1;
          kept_nxt = kept_r + 1'b1;
        end
        k_nxt = k_inc;
        if (k_inc == m_r) begin
          m_nxt     = kept_nxt;
          i_nxt     = '0;
          state_nxt = ST_CLR;
        end else begin
          state_nxt = ST_FRD;
        end
      end
      ST_CLR: begin
        bw_we   = 1'b1;
        par_we  = 1'b1;
        mark_we = 1'b1;
        lab_we  = 1'b1;
        i_nxt   = i_r + 1'b1;
        if (i_r == n_r) begin
          lbl_nxt = '0;
          k_nxt   = '0;
          if (m_r == '0) begin
            i_nxt     = VW'(1);
            state_nxt = ST_CRD;
          end else begin
            state_nxt = ST_BRD;
          end
        end
      end
      ST_BRD: state_nxt = ST_BW;
      ST_BW: begin
        vb        = e_rd.head;
        state_nxt = ST_BEX;
      end
      ST_BEX: begin
        if (e_rd.tail != e_rd.head && {1'b0, e_rd.weight} < bw_rd) begin
          bw_we  = 1'b1;
          bw_wa  = e_rd.head;
          bw_wd  = {1'b0, e_rd.weight};
          par_we = 1'b1;
          par_wa = e_rd.head;
          par_wd = e_rd.tail;
        end
        k_nxt = k_inc;
        if (k_inc == m_r) begin
          i_nxt     = VW'(1);
          state_nxt = ST_CRD;
        end else begin
          state_nxt = ST_BRD;
        end
      end
      ST_CRD: state_nxt = ST_CEX;
      ST_CEX: begin
        if (i_r != croot_r && bw_rd == NO_EDGE) begin
          out_valid_nxt  = 1'b1;
          out_total_nxt  = '0;
          out_status_nxt = STAT_UNREACHABLE;
          state_nxt      = ST_IDLE;
        end else if (i_r == n_r) begin
          i_nxt     = VW'(1);
          state_nxt = ST_WI;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_CRD;
        end
      end
      ST_WI: begin
        u_nxt = i_r;
        if (i_r != croot_r) begin
          state_nxt = ST_WADD;
        end else if (i_r == n_r) begin
          i_nxt     = VW'(1);
          state_nxt = (lbl_r == '0) ? ST_IDLE : ST_RRD;
          if (lbl_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_FOUND;
            out_total_nxt  = (|total_r[ACCW-1:32]) ? '1 : total_r[31:0];
          end
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      ST_WADD: begin
        total_nxt = total_r + ACCW'(bw_rd);
        state_nxt = ST_WEX;
      end
      ST_WEX: begin
        va = u_r;
        vb = u_r;
        if (u_r != croot_r && mark_rd == '0 && laba_rd == '0) begin
          mark_we = 1'b1;
          mark_wa = u_r;
          mark_wd = i_r;
          u_nxt   = par_rd;
          va      = par_rd;
        end else if (u_r != croot_r && mark_rd == i_r) begin
          lbl_nxt   = lbl_r + 1'b1;
          lab_we    = 1'b1;
          lab_wa    = u_r;
          lab_wd    = lbl_nxt;
          v_nxt     = par_rd;
          va        = par_rd;
          state_nxt = ST_CYC;
        end else if (i_r == n_r) begin
          i_nxt     = VW'(1);
          state_nxt = (lbl_r == '0) ? ST_IDLE : ST_RRD;
          if (lbl_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_FOUND;
            out_total_nxt  = (|total_r[ACCW-1:32]) ? '1 : total_r[31:0];
          end
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_WI;
        end
      end
      ST_CYC: begin
        va = v_r;
        if (v_r != u_r) begin
          lab_we = 1'b1;
          lab_wa = v_r;
          lab_wd = lbl_r;
          v_nxt  = par_rd;
          va     = par_rd;
        end else if (i_r == n_r) begin
          i_nxt     = VW'(1);
          state_nxt = ST_RRD;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_WI;
        end
      end
      ST_RRD: state_nxt = ST_REX;
      ST_REX: begin
        if (laba_rd == '0) begin
          lbl_nxt = lbl_r + 1'b1;
          lab_we  = 1'b1;
          lab_wd  = lbl_nxt;
        end
        if (i_r == n_r) begin
          k_nxt     = '0;
          kept_nxt  = '0;
          state_nxt = (m_r == '0) ? ST_ROOT : ST_KRD;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_RRD;
        end
      end
      ST_KRD: state_nxt = ST_KW;
      ST_KW: begin
        va        = e_rd.tail;
        vb        = e_rd.head;
        state_nxt = ST_KEX;
      end
      ST_KEX: begin
        if (laba_rd != labb_rd) begin
          e_we           = 1'b1;
          e_wdata.tail   = laba_rd;
          e_wdata.head   = labb_rd;
          e_wdata.weight = e_rd.weight - bw_rd[WB-1:0];
          kept_nxt       = kept_r + 1'b1;
        end
        k_nxt = k_inc;
        if (k_inc == m_r) begin
          m_nxt     = kept_nxt;
          state_nxt = ST_ROOT;
        end else begin
          state_nxt = ST_KRD;
        end
      end
      ST_ROOT: begin
        va        = croot_r;
        state_nxt = ST_ROOT2;
      end
      ST_ROOT2: begin
        croot_nxt = laba_rd;
        n_nxt     = lbl_r;
        i_nxt     = '0;
        state_nxt = ST_CLR;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vcnt_r      <= VW'(1);
      rcfg_r      <= VW'(1);
      ecnt_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vcnt_r      <= vcnt_nxt;
      rcfg_r      <= rcfg_nxt;
      ecnt_r      <= ecnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r          <= m_nxt;
    k_r          <= k_nxt;
    kept_r       <= kept_nxt;
    n_r          <= n_nxt;
    croot_r      <= croot_nxt;
    lbl_r        <= lbl_nxt;
    i_r          <= i_nxt;
    u_r          <= u_nxt;
    v_r          <= v_nxt;
    total_r      <= total_nxt;
    out_total_r  <= out_total_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ready         = (state_r == ST_IDLE) && !out_valid_r;
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_total_weight = out_total_r;
  assign out_status       = out_status_r;

  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !out_valid_r)
    else $error("result pending during solve");

  a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ecnt_r <= ECW'(MAX_E))
    else $error("edge count past capacity");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r == STAT_FOUND || out_status_r == STAT_UNREACHABLE
                     || out_status_r == STAT_OVERFLOW))
    else $error("bad status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STAT_FOUND) |-> (out_total_r == '0))
    else $error("nonzero total on failure");

endmodule

@@ src/mdst_edge_mem.sv @@
// Edge store: one write port, one registered read port.
module mdst_edge_mem
  import mdst_pkg::*;
(
  input  logic           clk,
  input  logic           we,
  input  logic [EAW-1:0] waddr,
  input  edge_t          wdata,
  input  logic [EAW-1:0] raddr,
  output edge_t          rdata
);

  edge_t mem [0:MAX_E-1];
  edge_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ bench/min_directed_spanning_tree_core_test.sv @@
// Self-checking testbench for the minimum arborescence solver core.
module min_directed_spanning_tree_core_test;
  import mdst_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int unsigned NO_W = 1 << WB;
  localparam int unsigned IDLE_LIMIT = 10000000;

  typedef struct {
    logic [31:0] total;
    logic [1:0]  status;
  } tree_result_t;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  logic [VW-1:0] in_edge_source;
  logic [VW-1:0] in_edge_target;
  logic [WB-1:0] in_edge_weight;
  logic          in_last_edge;
  logic          out_valid;
  logic          out_ready;
  logic [31:0]   out_total_weight;
  logic [1:0]    out_status;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [1:0]    cfg_index;
  logic [VW-1:0] cfg_data;

  min_directed_spanning_tree_core uut (.*);

  // predictor state
  logic [VW-1:0] vcount_reg;
  logic [VW-1:0] root_reg;
  int unsigned   graph_tail[$];
  int unsigned   graph_head[$];
  int unsigned   graph_weight[$];
  bit            graph_overflow;
  tree_result_t  tree_q[$];

  int  mismatches;
  int  idle_cycles;
  int  hold_req;
  int  stall_left;
  bit  no_idle;
  int  random_items;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  // Chu-Liu/Edmonds over the edges held for the current graph
  function automatic void solve_arborescence(output logic [31:0] tot, output logic [1:0] st);
    int unsigned n, root, m, i, k, u, v, guard, lab, kept, t, h, a, b;
    int unsigned et[$], eh[$], ew[$];
    int unsigned bw[0:MAX_V], bp[0:MAX_V], vm[0:MAX_V], cl[0:MAX_V];
    longint unsigned acc;
    tot = 0;
    acc = 0;
    n = (vcount_reg > MAX_V) ? MAX_V : vcount_reg;
    root = root_reg;
    if (root < 1 || root > n) begin
      st = STAT_UNREACHABLE;
      return;
    end
    for (k = 0; k < graph_tail.size(); k++) begin
      t = graph_tail[k];
      h = graph_head[k];
      if (t >= 1 && t <= n && h >= 1 && h <= n) begin
        et.push_back(t);
        eh.push_back(h);
        ew.push_back(graph_weight[k]);
      end
    end
    m = et.size();
    forever begin
      lab = 0;
      for (i = 0; i <= n; i++) begin
        cl[i] = 0;
        bp[i] = 0;
        vm[i] = 0;
        bw[i] = NO_W;
      end
      for (k = 0; k < m; k++) begin
        if (et[k] != eh[k] && ew[k] < bw[eh[k]]) begin
          bw[eh[k]] = ew[k];
          bp[eh[k]] = et[k];
        end
      end
      for (i = 1; i <= n; i++) begin
        if (i != root && bw[i] == NO_W) begin
          st = STAT_UNREACHABLE;
          return;
        end
      end
      for (i = 1; i <= n; i++) begin
        if (i == root) continue;
        acc += bw[i];
        u = i;
        guard = 0;
        while (u != root && vm[u] == 0 && cl[u] == 0 && guard <= n) begin
          vm[u] = i;
          u = bp[u];
          guard++;
        end
        if (u != root && u >= 1 && u <= n && vm[u] == i) begin
          v = bp[u];
          lab++;
          cl[u] = lab;
          guard = 0;
          while (v != u && v >= 1 && v <= n && guard <= n) begin
            cl[v] = lab;
            v = bp[v];
            guard++;
          end
        end
      end
      if (lab == 0) begin
        tot = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
        st = STAT_FOUND;
        return;
      end
      for (i = 1; i <= n; i++)
        if (cl[i] == 0) cl[i] = ++lab;
      kept = 0;
      for (k = 0; k < m; k++) begin
        h = eh[k];
        a = cl[et[k]];
        b = cl[h];
        if (a == b) continue;
        et[kept] = a;
        eh[kept] = b;
        ew[kept] = ew[k] - bw[h];
        kept++;
      end
      m = kept;
      n = lab;
      root = cl[root];
    end
  endfunction

  function automatic void record_edge(int unsigned src, int unsigned dst, int unsigned w,
                                      bit last);
    tree_result_t r;
    if (graph_tail.size() < MAX_E) begin
      graph_tail.push_back(src);
      graph_head.push_back(dst);
      graph_weight.push_back(w);
    end else begin
      graph_overflow = 1'b1;
    end
    if (!last) return;
    if (graph_overflow) begin
      r.total = 0;
      r.status = STAT_OVERFLOW;
    end else begin
      solve_arborescence(r.total, r.status);
    end
    tree_q.push_back(r);
    graph_tail.delete();
    graph_head.delete();
    graph_weight.delete();
    graph_overflow = 1'b0;
  endfunction

  // every task below starts and ends just after a rising edge
  task automatic send_edge(int unsigned src, int unsigned dst, int unsigned w, bit last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_edge_source <= src[VW-1:0];
    in_edge_target <= dst[VW-1:0];
    in_edge_weight <= w[WB-1:0];
    in_last_edge   <= last;
    do @(posedge clk); while (!in_ready);
    record_edge(src, dst, w, last);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tree_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    drain();
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[VW-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_VERTEX_COUNT) vcount_reg = val[VW-1:0];
    else if (idx == REG_ROOT_VERTEX) root_reg = val[VW-1:0];
  endtask

  task automatic set_graph(int unsigned n, int unsigned root);
    write_reg(REG_VERTEX_COUNT, n);
    write_reg(REG_ROOT_VERTEX, root);
  endtask

  function automatic int unsigned pick_weight();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(0, 15);
    if (r == 4) return 0;
    if (r == 5) return NO_W - 1;
    return $urandom_range(0, NO_W - 1);
  endfunction

  // random graph on vertices 1..n; mostly each non-root vertex gets an in-edge
  task automatic send_random_graph(int unsigned n, int unsigned root, int unsigned extra);
    int unsigned srcs[$], dsts[$], i, j;
    bit broken;
    broken = ($urandom_range(0, 9) == 0);
    for (i = 1; i <= n; i++) begin
      if (i == root || (broken && $urandom_range(0, 3) == 0)) continue;
      srcs.push_back($urandom_range(1, n));
      dsts.push_back(i);
    end
    for (i = 0; i < extra; i++) begin
      j = $urandom_range(0, 19);
      if (j == 0) begin
        srcs.push_back($urandom_range(0, 511));
        dsts.push_back($urandom_range(0, 511));
      end else begin
        srcs.push_back($urandom_range(1, n));
        dsts.push_back($urandom_range(1, n));
      end
    end
    if (n > 1 && $urandom_range(0, 3) != 0) begin
      srcs.push_back(root);
      dsts.push_back($urandom_range(1, n));
    end
    srcs.shuffle();
    for (i = 0; i < srcs.size(); i++) begin
      send_edge(srcs[i], dsts[i], pick_weight(), i == srcs.size() - 1);
      random_items++;
    end
  endtask

  task automatic test_defaults();
    send_edge(1, 1, NO_W - 1, 1'b1);
    send_edge(0, 511, 0, 1'b1);
  endtask

  task automatic test_directed();
    set_graph(4, 1);
    send_edge(1, 2, 10, 1'b0);
    send_edge(2, 3, 1, 1'b0);
    send_edge(3, 2, 1, 1'b0);
    send_edge(3, 4, 5, 1'b0);
    send_edge(1, 3, 8, 1'b0);
    send_edge(4, 4, 0, 1'b0);
    send_edge(4, 1, 0, 1'b1);
    send_edge(1, 2, 3, 1'b0);
    send_edge(1, 3, 3, 1'b1);
    send_edge(1, 2, NO_W - 1, 1'b0);
    send_edge(2, 3, NO_W - 1, 1'b0);
    send_edge(3, 4, NO_W - 1, 1'b1);
    send_edge(0, 2, 0, 1'b0);
    send_edge(1, 2, 0, 1'b0);
    send_edge(1, 3, 0, 1'b0);
    send_edge(1, 4, 0, 1'b0);
    send_edge(5, 4, 0, 1'b1);
    set_graph(0, 1);
    send_edge(1, 1, 5, 1'b1);
    set_graph(3, 0);
    send_edge(1, 2, 5, 1'b1);
    set_graph(3, 4);
    send_edge(1, 2, 5, 1'b1);
    write_reg(REG_UNUSED, 511);
    set_graph(2, 2);
    send_edge(2, 1, 7, 1'b1);
  endtask

  task automatic test_extremes();
    int unsigned i;
    set_graph(511, 256);
    for (i = 1; i < 256; i++) send_edge(i + 1, i, pick_weight(), 1'b0);
    send_edge(1, 256, 4, 1'b0);
    send_edge(256, 1, 9, 1'b1);
    set_graph(256, 1);
    send_random_graph(256, 1, 60);
  endtask

  task automatic test_overflow();
    int unsigned i;
    set_graph(8, 1);
    no_idle = 1'b1;
    for (i = 0; i <= MAX_E; i++)
      send_edge($urandom_range(1, 8), $urandom_range(1, 8), pick_weight(), i == MAX_E);
    no_idle = 1'b0;
    send_random_graph(8, 1, 6);
  endtask

  task automatic test_backpressure();
    int unsigned g;
    set_graph(5, 3);
    hold_req = 400;
    for (g = 0; g < 6; g++) send_random_graph(5, 3, 4);
    drain();
  endtask

  task automatic test_random();
    int unsigned n, root, r, g;
    g = 0;
    while (random_items < 950) begin
      if (g % 4 == 0) begin
        r = $urandom_range(0, 99);
        if (r < 80) n = $urandom_range(2, 8);
        else if (r < 96) n = $urandom_range(9, 40);
        else if (r < 98) n = $urandom_range(0, 1);
        else n = $urandom_range(257, 511);
        r = $urandom_range(0, 19);
        if (r == 0) root = 0;
        else if (r == 1) root = $urandom_range(0, 511);
        else root = $urandom_range(1, (n > MAX_V) ? MAX_V : ((n < 1) ? 1 : n));
        no_idle = ($urandom_range(0, 4) == 0);
        set_graph(n, root);
      end
      n = (vcount_reg > MAX_V) ? MAX_V : vcount_reg;
      if (n > 60) n = 60;
      send_random_graph(n < 1 ? 1 : n, root_reg, $urandom_range(0, 2 * n + 2));
      g++;
    end
    no_idle = 1'b0;
  endtask

  // result side: random stalls, with a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (hold_req > 0) begin
      stall_left = hold_req;
      hold_req = 0;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!no_idle) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    tree_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (tree_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: total=%0d status=%0d", out_total_weight, out_status);
      end else begin
        exp_r = tree_q.pop_front();
        if (exp_r.total !== out_total_weight || exp_r.status !== out_status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected total=%0d status=%0d, got total=%0d status=%0d",
                     exp_r.total, exp_r.status, out_total_weight, out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_edge_source = '0;
    in_edge_target = '0;
    in_edge_weight = '0;
    in_last_edge   = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_VERTEX_COUNT;
    cfg_data       = '0;
    vcount_reg     = 1;
    root_reg       = 1;
    graph_overflow = 1'b0;
    mismatches     = 0;
    idle_cycles    = 0;
    hold_req       = 0;
    no_idle        = 1'b0;
    random_items   = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_directed();
    test_extremes();
    test_overflow();
    test_backpressure();
    test_random();
    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && tree_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/mdst_pkg.sv
src/mdst_edge_mem.sv
src/min_directed_spanning_tree_core.sv
bench/min_directed_spanning_tree_core_test.sv
